### hw/rtl/iis_pkg.sv
// Shared types and constants for the indexed insert stack.
`default_nettype none
package iis_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;
	localparam int DEPTH_DEF = 32;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4,
		OP_READ   = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_NONE   = 3'd7
	} iis_op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} iis_status_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} iis_cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/indexed_insert_stack_unit.sv
// Top level of the indexed insert stack: control sequencer, cell row and read tree.
`default_nettype none
// Bounded stack of signed 32-bit words with push, pop, peek, clear and
// insert, delete or read at any position (0 is the bottom). The words live
// in a row of DEPTH cells; insert and delete move every affected cell to its
// neighbor at once, so they cost the same as push. An input transaction
// is taken when the unit is idle, executed in the S_EXEC state after that,
// and its result transaction lands in an output register that may wait for
// m_tready while the next input transaction is already being taken. Push,
// insert, delete, clear and every error result pass through S_IDLE and
// S_EXEC only; pop, peek and read that return a word also wait in S_READ
// until the registered OR tree carries the selected cell onto the read bus.
// Errors return data_out = -1 with status 1 (empty), 2 (bad position) or
// 3 (full); a bad position on insert is reported before full. Every result
// carries the entry count after the operation and an empty flag.
module indexed_insert_stack_unit
	import iis_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int POS_W = $clog2(DEPTH + 1),
	localparam int S_W   = ((OP_W + POS_W + DATA_W + 7) / 8) * 8,
	localparam int M_W   = ((DATA_W + ST_W + POS_W + 1 + 7) / 8) * 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	// operation [OP_W-1:0], position [POS_W], data_in [DATA_W], zero pad
	input  wire  [S_W-1:0]   s_tdata,
	output logic             m_tvalid,
	input  wire              m_tready,
	// data_out [DATA_W], status [ST_W], count [POS_W], empty_res [1], zero pad
	output logic [M_W-1:0]   m_tdata
);

	localparam int LVL    = $clog2(DEPTH);
	localparam int WAIT_W = $clog2(LVL + 1);
	localparam logic [POS_W-1:0]  FULL_CNT = POS_W'(DEPTH);
	localparam logic [WAIT_W-1:0] WAIT_END = WAIT_W'(LVL);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	state_t             state_q;
	iis_op_t            op_q;
	logic [POS_W-1:0]   pos_q;
	logic [DATA_W-1:0]  data_q;
	logic [POS_W-1:0]   count_q;
	logic [POS_W-1:0]   rd_idx_q;
	logic [WAIT_W-1:0]  wait_q;

	logic               m_tvalid_q;
	logic [DATA_W-1:0]  dout_q;
	iis_status_t        status_q;
	logic [POS_W-1:0]   res_count_q;

	// Execute-stage decisions
	iis_status_t        ex_status;
	logic [POS_W-1:0]   ex_count;
	logic [POS_W-1:0]   ex_idx;
	logic [POS_W-1:0]   ex_pos;
	logic               ex_read;
	logic               ex_up;
	logic               ex_down;
	logic               out_free;
	logic               ex_fire;
	logic               rd_done;
	logic               res_load;

	iis_cell_cmd_t              cmd;
	logic [DEPTH-1:0][DATA_W-1:0] words;
	logic [DEPTH-1:0][DATA_W-1:0] leaves;
	logic [DATA_W-1:0]            rd_word;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		ex_status = ST_OK;
		ex_count  = count_q;
		ex_idx    = pos_q;
		ex_pos    = pos_q;
		ex_read   = 1'b0;
		ex_up     = 1'b0;
		ex_down   = 1'b0;
		case (op_q)
			OP_PUSH: begin
				ex_pos = count_q;
				if (count_q == FULL_CNT) begin
					ex_status = ST_FULL;
				end else begin
					ex_up    = 1'b1;
					ex_count = count_q + 1'b1;
				end
			end
			OP_POP, OP_PEEK: begin
				ex_idx = count_q - 1'b1;
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else begin
					ex_read = 1'b1;
					if (op_q == OP_POP) begin
						ex_count = count_q - 1'b1;
					end
				end
			end
			OP_INSERT: begin
				if (pos_q > count_q) begin
					ex_status = ST_BADPOS;
				end else if (count_q == FULL_CNT) begin
					ex_status = ST_FULL;
				end else begin
					ex_up    = 1'b1;
					ex_count = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos_q >= count_q) begin
					ex_status = ST_BADPOS;
				end else begin
					ex_down  = 1'b1;
					ex_count = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (pos_q >= count_q) begin
					ex_status = ST_BADPOS;
				end else begin
					ex_read = 1'b1;
				end
			end
			OP_CLEAR: begin
				ex_count = '0;
			end
			default: begin
			end
		endcase
	end

	// Shift the row only in the cycle the result is committed.
	assign ex_fire        = (state_q == S_EXEC) && !ex_read && out_free;
	assign cmd.shift_up   = ex_fire && ex_up;
	assign cmd.shift_down = ex_fire && ex_down;

	// A word read finishes once the tree has settled and the output is free.
	assign rd_done  = (state_q == S_READ) && (wait_q == WAIT_END) && out_free;
	assign res_load = ex_fire || rd_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NONE;
			pos_q       <= '0;
			data_q      <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			wait_q      <= '0;
			m_tvalid_q  <= 1'b0;
			dout_q      <= '0;
			status_q    <= ST_OK;
			res_count_q <= '0;
		end else begin
			// raise valid on a new result, drop it once the result is taken
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= iis_op_t'(s_tdata[OP_W-1:0]);
						pos_q   <= s_tdata[OP_W +: POS_W];
						data_q  <= s_tdata[OP_W+POS_W +: DATA_W];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ex_read) begin
						// launch the read through the OR tree
						rd_idx_q <= ex_idx;
						wait_q   <= '0;
						count_q  <= ex_count;
						state_q  <= S_READ;
					end else if (out_free) begin
						dout_q      <= '1;
						status_q    <= ex_status;
						res_count_q <= ex_count;
						count_q     <= ex_count;
						state_q     <= S_IDLE;
					end
				end
				S_READ: begin
					if (wait_q == WAIT_END) begin
						if (out_free) begin
							dout_q      <= rd_word;
							status_q    <= ST_OK;
							res_count_q <= count_q;
							state_q     <= S_IDLE;
						end
					end else begin
						wait_q <= wait_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Row of cells; each neighbor link carries a word one slot per cycle in which the row shifts.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] lower_w;
		logic [DATA_W-1:0] upper_w;
		if (i == 0) begin : g_bot
			assign lower_w = '0;
		end else begin : g_low
			assign lower_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign upper_w = words[i];
		end else begin : g_up
			assign upper_w = words[i+1];
		end
		iis_cell #(
			.POS_W (POS_W),
			.INDEX (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.pos    (ex_pos),
			.data   (data_q),
			.lower  (lower_w),
			.upper  (upper_w),
			.rd_idx (rd_idx_q),
			.word   (words[i]),
			.leaf   (leaves[i])
		);
	end

	iis_or_tree #(
		.N (DEPTH)
	) u_tree (
		.clk     (clk),
		.leaf_in (leaves),
		.root    (rd_word)
	);

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_W-1:0]             = dout_q;
		m_tdata[DATA_W +: ST_W]         = status_q;
		m_tdata[DATA_W+ST_W +: POS_W]   = res_count_q;
		m_tdata[DATA_W+ST_W+POS_W]      = (res_count_q == '0);
	end

endmodule
`default_nettype wire

### hw/rtl/iis_cell.sv
// One storage cell of the stack row: holds a word and trades it with its neighbors.
`default_nettype none
module iis_cell
	import iis_pkg::*;
#(
	parameter int POS_W = 6,
	parameter int INDEX = 0
) (
	input  wire                  clk,
	input  wire iis_cell_cmd_t   cmd,
	input  wire  [POS_W-1:0]     pos,
	input  wire  [DATA_W-1:0]    data,
	input  wire  [DATA_W-1:0]    lower,
	input  wire  [DATA_W-1:0]    upper,
	input  wire  [POS_W-1:0]     rd_idx,
	output logic [DATA_W-1:0]    word,
	output logic [DATA_W-1:0]    leaf
);

	localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

	logic [DATA_W-1:0] word_q;

	// Insert or push: take new word at the slot, take lower neighbor above it.
	// Delete: take upper neighbor at and above the slot.
	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (IDX == pos) begin
				word_q <= data;
			end else if (IDX > pos) begin
				word_q <= lower;
			end
		end else if (cmd.shift_down) begin
			if (IDX >= pos) begin
				word_q <= upper;
			end
		end
	end

	assign word = word_q;
	assign leaf = (rd_idx == IDX) ? word_q : '0;

endmodule
`default_nettype wire

### hw/rtl/iis_or_tree.sv
// Registered OR tree that collects the selected cell word onto one read bus.
`default_nettype none
module iis_or_tree
	import iis_pkg::*;
#(
	parameter int N = DEPTH_DEF
) (
	input  wire                       clk,
	input  wire  [N-1:0][DATA_W-1:0]  leaf_in,
	output logic [DATA_W-1:0]         root
);

	localparam int LVL = $clog2(N);
	localparam int TN  = 1 << LVL;

	logic [DATA_W-1:0] leaf   [TN];
	logic [DATA_W-1:0] node_q [1:TN-1];

	// Pad missing leaves with zero.
	for (genvar k = 0; k < TN; k++) begin : g_leaf
		if (k < N) begin : g_real
			assign leaf[k] = leaf_in[k];
		end else begin : g_pad
			assign leaf[k] = '0;
		end
	end

	// Heap-ordered nodes: node k combines nodes 2k and 2k+1, one level per cycle.
	for (genvar k = 1; k < TN; k++) begin : g_node
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		if (2 * k >= TN) begin : g_bottom
			assign lhs = leaf[2*k-TN];
			assign rhs = leaf[2*k+1-TN];
		end else begin : g_inner
			assign lhs = node_q[2*k];
			assign rhs = node_q[2*k+1];
		end
		always_ff @(posedge clk) begin
			node_q[k] <= lhs | rhs;
		end
	end

	assign root = node_q[1];

endmodule
`default_nettype wire
